### hw/rtl/pac_pkg.sv
// Shared types, constants and helpers for the pixel alpha compositor.
package pac_pkg;

  localparam int unsigned NUM_CH  = 3;
  localparam int unsigned NUM_W   = 24;
  localparam int unsigned DEN_W   = 16;
  localparam int unsigned Q_BITS  = 8;
  localparam logic [7:0]  FULL    = 8'hFF;
  localparam logic [31:0] MOD_RST = 32'hFFFF_FFFF;

  localparam logic REG_MODULATE = 1'b0;
  localparam logic REG_ADDITIVE = 1'b1;

  typedef logic [NUM_CH-1:0][7:0]       chan_t;
  typedef logic [NUM_CH-1:0][NUM_W-1:0] num_t;

  // result bits known before the division, carried alongside the divider
  typedef struct packed {
    logic  partial;
    chan_t col;
    logic [7:0] alpha;
  } pac_sb_t;

  // floor(x/255) for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  function automatic logic [7:0] sat8(input logic [8:0] x);
    return x[8] ? FULL : x[7:0];
  endfunction

endpackage

### hw/rtl/pac_cfg.sv
// APB register file: modulate colour and additive mode.
module pac_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] modulate_color,
  output logic        additive_mode
);
  import pac_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulate_color <= MOD_RST;
      additive_mode  <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_MODULATE: modulate_color <= pwdata;
        REG_ADDITIVE: additive_mode  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MODULATE: prdata = modulate_color;
      REG_ADDITIVE: prdata = {31'd0, additive_mode};
      default:      prdata = '0;
    endcase
  end

endmodule

### hw/rtl/pac_div.sv
// Pipelined restoring divider, one quotient bit per stage, three channels.
module pac_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_vld,
  input  pac_pkg::num_t             in_num,
  input  logic [pac_pkg::DEN_W-1:0] in_den,
  input  pac_pkg::pac_sb_t          in_sb,
  output logic                      out_vld,
  output pac_pkg::chan_t            out_q,
  output pac_pkg::pac_sb_t          out_sb
);
  import pac_pkg::*;

  logic                 vld [0:Q_BITS];
  logic [DEN_W-1:0]     den [0:Q_BITS];
  num_t                 rem [0:Q_BITS];
  chan_t                quo [0:Q_BITS];
  pac_sb_t              sb  [0:Q_BITS];

  assign vld[0] = in_vld;
  assign den[0] = in_den;
  assign rem[0] = in_num;
  assign quo[0] = '0;
  assign sb[0]  = in_sb;

  for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
    localparam int unsigned J = Q_BITS - 1 - k;
    logic [NUM_W-1:0] dsh;
    num_t             rem_next;
    chan_t            quo_next;

    assign dsh = NUM_W'(den[k]) << J;

    always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (rem[k][c] >= dsh) begin
          rem_next[c] = rem[k][c] - dsh;
          quo_next[c] = {quo[k][c][6:0], 1'b1};
        end else begin
          rem_next[c] = rem[k][c];
          quo_next[c] = {quo[k][c][6:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else     vld[k+1] <= vld[k];
    end

    always_ff @(posedge clk) begin
      den[k+1] <= den[k];
      rem[k+1] <= rem_next;
      quo[k+1] <= quo_next;
      sb[k+1]  <= sb[k];
    end
  end

  assign out_vld = vld[Q_BITS];
  assign out_q   = quo[Q_BITS];
  assign out_sb  = sb[Q_BITS];

  // in the partial case a full restoring pass leaves every remainder below the divisor
  a_rem_lt_den: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_sb.partial |-> (rem[Q_BITS][0] < NUM_W'(den[Q_BITS])) &&
      (rem[Q_BITS][1] < NUM_W'(den[Q_BITS])) && (rem[Q_BITS][2] < NUM_W'(den[Q_BITS])))
    else $error("divider remainder not below divisor");

endmodule

### hw/rtl/pixel_alpha_compositor.sv
// Top level: source-over / additive compositing of one BGRA pixel word per clock.
// Pipeline from the start edge to the done strobe: 4 arithmetic stages,
//   8 divider stages, 1 output register; every path runs the same depth.
// Throughput: one word per clock; busy is high only in reset.
// The receiver cannot stall: each result shows for one cycle with done.
// Reset (rst, synchronous) empties the pipe and restores the registers.
module pixel_alpha_compositor (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  src_blue,
  input  logic [7:0]  src_green,
  input  logic [7:0]  src_red,
  input  logic [7:0]  src_alpha,
  input  logic [7:0]  dst_blue,
  input  logic [7:0]  dst_green,
  input  logic [7:0]  dst_red,
  input  logic [7:0]  dst_alpha,
  output logic        done,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic [7:0]  out_alpha
);
  import pac_pkg::*;

  logic [31:0] modulate_color;
  logic        additive_mode;

  pac_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .modulate_color, .additive_mode
  );

  assign busy = rst;

  // stage 1: modulate the source
  logic  acc;
  chan_t src_c, mod_c;
  logic  v1, add1;
  chan_t s1, d1;
  logic [7:0] a1, da1;

  assign acc   = start && !busy;
  assign src_c = {src_red, src_green, src_blue};
  assign mod_c = modulate_color[23:0];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= acc;
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) s1[c] <= div255(16'(src_c[c]) * 16'(mod_c[c]));
    a1   <= div255(16'(src_alpha) * 16'(modulate_color[31:24]));
    d1   <= {dst_red, dst_green, dst_blue};
    da1  <= dst_alpha;
    add1 <= additive_mode;
  end

  // stage 2: alpha-weighted terms and the partial-case weights
  logic  v2, add2;
  chan_t s2, d2, st2, dt2;
  logic [7:0]  a2, da2;
  logic [15:0] ad2, as2;
  logic [7:0]  ia1;

  assign ia1 = FULL - a1;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) begin
      st2[c] <= div255(16'(s1[c]) * 16'(a1));
      dt2[c] <= div255(16'(d1[c]) * 16'(ia1));
    end
    ad2  <= 16'(da1) * 16'(ia1);
    as2  <= {a1, 8'd0} - 16'(a1);
    s2   <= s1;
    d2   <= d1;
    a2   <= a1;
    da2  <= da1;
    add2 <= add1;
  end

  // stage 3: partial products for the weighted average; simple cases settle here
  logic    v3;
  num_t    p3d, p3s;
  logic [DEN_W-1:0] den3;
  pac_sb_t sb2, sb3;

  always_comb begin
    sb2.partial = 1'b0;
    sb2.alpha   = da2;
    priority if (add2) begin
      for (int c = 0; c < NUM_CH; c++) sb2.col[c] = sat8(9'(d2[c]) + 9'(st2[c]));
    end else if (da2 == FULL) begin
      for (int c = 0; c < NUM_CH; c++) sb2.col[c] = sat8(9'(dt2[c]) + 9'(st2[c]));
    end else if (da2 == 8'd0) begin
      sb2.col   = s2;
      sb2.alpha = a2;
    end else begin
      sb2.partial = 1'b1;
      sb2.col     = '0;
      // combined alpha never exceeds 255*255, so no clip is needed
      sb2.alpha   = div255(ad2 + as2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) begin
      p3d[c] <= NUM_W'(d2[c]) * NUM_W'(ad2);
      p3s[c] <= NUM_W'(s2[c]) * NUM_W'(as2);
    end
    // divisor forced to one outside the partial case
    den3 <= sb2.partial ? (ad2 + as2) : 16'd1;
    sb3  <= sb2;
  end

  // stage 4: numerator sums
  logic    v4;
  num_t    num4;
  logic [DEN_W-1:0] den4;
  pac_sb_t sb4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) num4[c] <= p3d[c] + p3s[c];
    den4 <= den3;
    sb4  <= sb3;
  end

  // stages 5..12: divider (weighted average never exceeds 255, so 8 bits suffice)
  logic    vq;
  chan_t   q;
  pac_sb_t sbq;

  pac_div u_div (
    .clk, .rst,
    .in_vld (v4), .in_num (num4), .in_den (den4), .in_sb (sb4),
    .out_vld(vq), .out_q  (q),    .out_sb (sbq)
  );

  // stage 13: output register
  chan_t col_o;

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vq;
  end

  always_ff @(posedge clk) begin
    col_o     <= sbq.partial ? q : sbq.col;
    out_alpha <= sbq.alpha;
  end

  assign out_blue  = col_o[0];
  assign out_green = col_o[1];
  assign out_red   = col_o[2];

  a_done_from_s1: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(v1, 12))
    else $error("result without matching stage-1 word");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    v4 |-> den4 != '0)
    else $error("zero divisor entered divider");

  a_done_from_s4: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(v4, 9))
    else $error("result without matching stage-4 word");

endmodule
